### rtl/cfpr_pkg.sv
// ----------------------------------------------------------------------------
// cfpr_pkg: shared types and constants of the framed packet receiver
// Header bytes, parser phase codes, event codes, the result record and the
// byte-wide CRC-16 (poly 0x1021, MSB first) update.
// ----------------------------------------------------------------------------
`default_nettype none

package cfpr_pkg;

  // frame sync bytes
  localparam logic [7:0] HdrFirst  = 8'h10;
  localparam logic [7:0] HdrSecond = 8'h23;
  localparam logic [15:0] CrcPoly  = 16'h1021;

  // configuration register indexes
  localparam logic [1:0] CfgAckType     = 2'd0;
  localparam logic [1:0] CfgDeliverType = 2'd1;
  localparam logic [1:0] CfgCrcInit     = 2'd2;

  // reset values of the configuration registers
  localparam logic [7:0]  AckTypeRst     = 8'd0;
  localparam logic [7:0]  DeliverTypeRst = 8'd1;
  localparam logic [15:0] CrcInitRst     = 16'd0;

  // parser phases
  localparam logic [3:0] PhHunt1 = 4'd0;
  localparam logic [3:0] PhHunt2 = 4'd1;
  localparam logic [3:0] PhSeq   = 4'd2;
  localparam logic [3:0] PhKind  = 4'd3;
  localparam logic [3:0] PhCmd   = 4'd4;
  localparam logic [3:0] PhLen   = 4'd5;
  localparam logic [3:0] PhData  = 4'd6;
  localparam logic [3:0] PhTrl1  = 4'd7;
  localparam logic [3:0] PhTrl2  = 4'd8;

  // result event codes
  typedef enum logic [2:0] {
    EvNone    = 3'd0,
    EvPayload = 3'd1,
    EvGood    = 3'd2,
    EvBadCrc  = 3'd3,
    EvTimeout = 3'd4
  } event_e;

  // configuration register set
  typedef struct packed {
    logic [7:0]  ack_type_code;
    logic [7:0]  deliver_type_code;
    logic [15:0] crc_init_value;
  } cfg_t;

  // one result item
  typedef struct packed {
    event_e      event_kind;
    logic [7:0]  payload_byte;
    logic [7:0]  payload_index;
    logic [7:0]  frame_seq;
    logic [7:0]  frame_kind;
    logic [7:0]  frame_command;
    logic [7:0]  frame_length;
    logic        send_ack;
    logic        deliver;
    logic        reply_seen;
  } res_t;

  // CRC-16 update by one byte, MSB first
  function automatic logic [15:0] crc16_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

`default_nettype wire

### rtl/cfpr_parser.sv
// ----------------------------------------------------------------------------
// cfpr_parser: frame parser and CRC check
// Steps the frame state by one byte or timeout per accepted item and forms
// the matching result in the same cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_parser (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                step_i,      // item accepted this cycle
  input  wire                func_i,      // 1: receive timeout
  input  wire  [7:0]         rx_byte_i,
  input  wire                awaiting_i,
  input  cfpr_pkg::cfg_t     cfg_i,
  output cfpr_pkg::res_t     res_o        // valid when step_i is high
);
  import cfpr_pkg::*;

  logic [3:0]  phase_q,   phase_d;
  logic [7:0]  seq_q,     seq_d;
  logic [7:0]  kind_q,    kind_d;
  logic [7:0]  cmd_q,     cmd_d;
  logic [7:0]  len_q,     len_d;
  logic [7:0]  count_q,   count_d;
  logic [15:0] crc_q,     crc_d;
  logic [7:0]  trl_hi_q,  trl_hi_d;

  logic [7:0]  count_inc;
  logic [15:0] trailer;

  assign count_inc = count_q + 8'd1;
  assign trailer   = {trl_hi_q, rx_byte_i};

  // next state and result
  always_comb begin
    phase_d  = phase_q;
    seq_d    = seq_q;
    kind_d   = kind_q;
    cmd_d    = cmd_q;
    len_d    = len_q;
    count_d  = count_q;
    crc_d    = crc_q;
    trl_hi_d = trl_hi_q;

    res_o = '0;
    res_o.event_kind = EvNone;

    if (func_i) begin
      // timeout: abort and clear the frame
      if (phase_q != PhHunt1) begin
        res_o.event_kind = EvTimeout;
      end
      phase_d  = PhHunt1;
      seq_d    = '0;
      kind_d   = '0;
      cmd_d    = '0;
      len_d    = '0;
      count_d  = '0;
      trl_hi_d = '0;
    end else begin
      unique case (phase_q)
        PhHunt2: begin
          if (rx_byte_i == HdrSecond) begin
            count_d = '0;
            crc_d   = cfg_i.crc_init_value;
            phase_d = PhSeq;
          end
        end
        PhSeq: begin
          seq_d   = rx_byte_i;
          phase_d = PhKind;
        end
        PhKind: begin
          kind_d  = rx_byte_i;
          phase_d = PhCmd;
        end
        PhCmd: begin
          cmd_d   = rx_byte_i;
          phase_d = PhLen;
        end
        PhLen: begin
          len_d   = rx_byte_i;
          phase_d = (rx_byte_i != 8'd0) ? PhData : PhTrl1;
        end
        PhData: begin
          res_o.event_kind    = EvPayload;
          res_o.payload_byte  = rx_byte_i;
          res_o.payload_index = count_q;
          crc_d   = crc16_feed(crc_q, rx_byte_i);
          count_d = count_inc;
          if (count_inc == len_q) begin
            phase_d = PhTrl1;
          end
        end
        PhTrl1: begin
          trl_hi_d = rx_byte_i;
          phase_d  = PhTrl2;
        end
        PhTrl2: begin
          if (trailer == crc_q) begin
            res_o.event_kind = EvGood;
            res_o.send_ack   = (kind_q != cfg_i.ack_type_code);
            res_o.reply_seen = awaiting_i;
            res_o.deliver    = !awaiting_i && (kind_q == cfg_i.deliver_type_code);
          end else begin
            res_o.event_kind = EvBadCrc;
          end
          phase_d = PhHunt1;
        end
        default: begin
          // first header hunt
          phase_d = (rx_byte_i == HdrFirst) ? PhHunt2 : PhHunt1;
        end
      endcase
    end

    // header registers as they stand after this item
    res_o.frame_seq     = seq_d;
    res_o.frame_kind    = kind_d;
    res_o.frame_command = cmd_d;
    res_o.frame_length  = len_d;
  end

  // frame state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PhHunt1;
      seq_q    <= '0;
      kind_q   <= '0;
      cmd_q    <= '0;
      len_q    <= '0;
      count_q  <= '0;
      crc_q    <= CrcInitRst;
      trl_hi_q <= '0;
    end else if (step_i) begin
      phase_q  <= phase_d;
      seq_q    <= seq_d;
      kind_q   <= kind_d;
      cmd_q    <= cmd_d;
      len_q    <= len_d;
      count_q  <= count_d;
      crc_q    <= crc_d;
      trl_hi_q <= trl_hi_d;
    end
  end

endmodule

`default_nettype wire

### rtl/cfpr_skid.sv
// ----------------------------------------------------------------------------
// cfpr_skid: two-entry output buffer
// Output register plus a skid register, so the input ready depends only on
// local state and a result can be pushed while the previous one waits.
// ----------------------------------------------------------------------------
`default_nettype none

module cfpr_skid (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                push_i,
  input  cfpr_pkg::res_t     push_res_i,
  output logic               ready_o,     // room for one more item
  output logic               valid_o,
  input  wire                pop_ready_i,
  output cfpr_pkg::res_t     res_o
);
  import cfpr_pkg::*;

  logic out_valid_q;
  logic skid_valid_q;
  res_t out_q;
  res_t skid_q;
  logic pop;

  assign ready_o = !skid_valid_q;
  assign valid_o = out_valid_q;
  assign res_o   = out_q;
  assign pop     = out_valid_q && pop_ready_i;

  // control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop) begin
        if (skid_valid_q) begin
          skid_valid_q <= 1'b0;
        end else begin
          out_valid_q <= push_i;
        end
      end else if (push_i) begin
        if (out_valid_q) begin
          skid_valid_q <= 1'b1;
        end else begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    if (pop) begin
      if (skid_valid_q) begin
        out_q <= skid_q;
      end else if (push_i) begin
        out_q <= push_res_i;
      end
    end else if (push_i) begin
      if (out_valid_q) begin
        skid_q <= push_res_i;
      end else begin
        out_q <= push_res_i;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/crc_framed_packet_receiver_core.sv
// A result is registered in the output buffer before it reaches the master side.
// Throughput: one item per cycle while the skid register is free; next state and
// the CRC update are combinational, and a two-entry output buffer absorbs stalls.
// Reset (rst_ni low, asynchronous): parser to first header hunt, frame registers
// and CRC cleared, configuration back to its defaults, output buffer empty.
// ----------------------------------------------------------------------------
// crc_framed_packet_receiver_core: framed packet receiver top level
// Hunts for the 0x10 0x23 header, latches the frame header, streams payload
// bytes out and checks the CRC-16 trailer of each frame.
// ----------------------------------------------------------------------------
`default_nettype none

module crc_framed_packet_receiver_core (
  input  wire         clk_i,
  input  wire         rst_ni,
  // configuration write channel
  input  wire         cfg_valid_i,
  output logic        cfg_ready_o,
  input  wire  [1:0]  cfg_index_i,
  input  wire  [15:0] cfg_data_i,
  // input items
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [15:0] s_axis_tdata,   // [7:0] rx_byte, [8] awaiting_reply, rest zero
  input  wire  [0:0]  s_axis_tuser,   // [0] func
  // result items
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [55:0] m_axis_tdata,   // [7:0] payload_byte, [15:8] payload_index,
                                      // [23:16] frame_seq, [31:24] frame_kind,
                                      // [39:32] frame_command, [47:40] frame_length,
                                      // [48] send_ack, [49] deliver, [50] reply_seen
  output logic [2:0]  m_axis_tuser    // [2:0] event_kind
);
  import cfpr_pkg::*;

  cfg_t cfg_q;
  res_t step_res;
  res_t out_res;
  logic step;

  // configuration registers, always writable
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.ack_type_code     <= AckTypeRst;
      cfg_q.deliver_type_code <= DeliverTypeRst;
      cfg_q.crc_init_value    <= CrcInitRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CfgAckType:     cfg_q.ack_type_code     <= cfg_data_i[7:0];
        CfgDeliverType: cfg_q.deliver_type_code <= cfg_data_i[7:0];
        CfgCrcInit:     cfg_q.crc_init_value    <= cfg_data_i;
        default:        ;
      endcase
    end
  end

  assign step = s_axis_tvalid && s_axis_tready;

  cfpr_parser u_parser (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .step_i     (step),
    .func_i     (s_axis_tuser[0]),
    .rx_byte_i  (s_axis_tdata[7:0]),
    .awaiting_i (s_axis_tdata[8]),
    .cfg_i      (cfg_q),
    .res_o      (step_res)
  );

  cfpr_skid u_skid (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (step),
    .push_res_i  (step_res),
    .ready_o     (s_axis_tready),
    .valid_o     (m_axis_tvalid),
    .pop_ready_i (m_axis_tready),
    .res_o       (out_res)
  );

  // pack the result item
  assign m_axis_tuser = out_res.event_kind;
  assign m_axis_tdata = {5'd0,
                         out_res.reply_seen,
                         out_res.deliver,
                         out_res.send_ack,
                         out_res.frame_length,
                         out_res.frame_command,
                         out_res.frame_kind,
                         out_res.frame_seq,
                         out_res.payload_index,
                         out_res.payload_byte};

endmodule

`default_nettype wire
